// ----- sv/hoasl_pkg.sv -----
// hoasl_pkg: shared constants, register codes and the arctangent step table
// for the hard or atan soft limiter; depends on nothing else
`timescale 1ns / 1ps

package hoasl_pkg;

   // magnitudes wider than this many bits are halved before the cordic
   localparam int NORM_BITS = 46;

   // pi in q2.13
   localparam int PI_BITS = 15;
   localparam logic [PI_BITS-1:0] PI_Q13 = 15'd25736;

   // the range operand enters the cordic scaled by 2^13
   localparam int X_SHIFT = 13;

   // cordic angle accumulator, units of pi * 2^-30
   localparam int MAX_STAGES  = 32;
   localparam int ANGLE_BITS  = 32;
   localparam int ROUND_SHIFT = 30;

   typedef enum logic [1:0] {
      CSR_GAIN,
      CSR_BOTTOM,
      CSR_TOP,
      CSR_MODE
   } csr_index_type;

   typedef enum logic {
      MODE_LINEAR,
      MODE_ATAN
   } curve_mode_type;

   // round(atan(2^-i) / pi * 2^30)
   function automatic logic signed [ANGLE_BITS-1:0] atan_entry(input int unsigned idx);
      logic signed [ANGLE_BITS-1:0] val;
      case (idx)
         0:  val = 32'sd268435456;
         1:  val = 32'sd158466703;
         2:  val = 32'sd83729454;
         3:  val = 32'sd42502378;
         4:  val = 32'sd21333666;
         5:  val = 32'sd10677233;
         6:  val = 32'sd5339919;
         7:  val = 32'sd2670123;
         8:  val = 32'sd1335082;
         9:  val = 32'sd667543;
         10: val = 32'sd333772;
         11: val = 32'sd166886;
         12: val = 32'sd83443;
         13: val = 32'sd41722;
         14: val = 32'sd20861;
         15: val = 32'sd10430;
         16: val = 32'sd5215;
         17: val = 32'sd2608;
         18: val = 32'sd1304;
         19: val = 32'sd652;
         20: val = 32'sd326;
         21: val = 32'sd163;
         22: val = 32'sd81;
         23: val = 32'sd41;
         24: val = 32'sd20;
         25: val = 32'sd10;
         26: val = 32'sd5;
         27: val = 32'sd3;
         28: val = 32'sd1;
         29: val = 32'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- sv/hoasl_front.sv -----
// hoasl_front: gain multiply, linear clamp, offset from mid level, range
// normalisation and cordic start vector; uses hoasl_pkg
`timescale 1ns / 1ps

module hoasl_front #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 12,
   parameter int DATA_WIDTH   = 50
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_take,
   input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] cfg_gain,
   input  logic signed [SAMPLE_WIDTH-1:0] cfg_bottom,
   input  logic signed [SAMPLE_WIDTH-1:0] cfg_top,
   input  logic signed [SAMPLE_WIDTH-1:0] cfg_mid,
   input  logic        [SAMPLE_WIDTH-1:0] cfg_range,
   output logic                           out_valid,
   input  logic                           out_take,
   output logic signed [DATA_WIDTH-1:0]   out_x,
   output logic signed [DATA_WIDTH-1:0]   out_y,
   output logic signed [SAMPLE_WIDTH-1:0] out_lin
);

   localparam int W   = SAMPLE_WIDTH;
   localparam int PW  = 2 * W;
   localparam int DW  = PW + 1;
   localparam int ADW = PW;
   localparam int NW  = (ADW > hoasl_pkg::NORM_BITS) ? hoasl_pkg::NORM_BITS : ADW;
   localparam int YMW = NW + hoasl_pkg::PI_BITS;

   localparam logic signed [PW-1:0] HALF = PW'(2 ** (FRAC_BITS - 1));
   localparam logic signed [PW-1:0] SMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [PW-1:0] SMIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

   // stage valid bits and flow control
   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;
   logic take1, take2, take3, take4;

   assign take4   = !vld4_ff || out_take;
   assign take3   = !vld3_ff || take4;
   assign take2   = !vld2_ff || take3;
   assign take1   = !vld1_ff || take2;
   assign in_take = take1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (take1) vld1_ff <= in_valid;
         if (take2) vld2_ff <= vld1_ff;
         if (take3) vld3_ff <= vld2_ff;
         if (take4) vld4_ff <= vld3_ff;
      end
   end

   // stage 1: exact product
   logic signed [PW-1:0] prod_ff, prod_in;
   assign prod_in = in_sample * cfg_gain;

   always_ff @(posedge clock) begin
      if (take1) prod_ff <= prod_in;
   end

   // stage 2: round, linear clamp, offset from mid and its magnitude
   logic signed [PW-1:0]  rounded;
   logic signed [PW-1:0]  sat_wide;
   logic signed [W-1:0]   sat;
   logic signed [W-1:0]   lin2_in, lin2_ff;
   logic signed [DW-1:0]  diff;
   logic signed [DW-1:0]  diff_abs;
   logic        [ADW-1:0] ad_in, ad_ff;
   logic                  neg2_in, neg2_ff;

   always_comb begin
      rounded = (prod_ff + HALF) >>> FRAC_BITS;
      if (rounded > SMAX)
         sat_wide = SMAX;
      else if (rounded < SMIN)
         sat_wide = SMIN;
      else
         sat_wide = rounded;
      sat = sat_wide[W-1:0];
      if (sat < cfg_bottom)
         lin2_in = cfg_bottom;
      else if (sat > cfg_top)
         lin2_in = cfg_top;
      else
         lin2_in = sat;
      diff     = {rounded[PW-1], rounded} - {{(DW-W){cfg_mid[W-1]}}, cfg_mid};
      neg2_in  = diff[DW-1];
      diff_abs = neg2_in ? -diff : diff;
      ad_in    = diff_abs[ADW-1:0];
   end

   always_ff @(posedge clock) begin
      if (take2) begin
         lin2_ff <= lin2_in;
         ad_ff   <= ad_in;
         neg2_ff <= neg2_in;
      end
   end

   // stage 3: halve both magnitudes until the offset fits the cordic
   logic [NW-1:0] ad_n_in, ad_n_ff;
   logic [W-1:0]  r_n_in, r_n_ff;
   logic signed [W-1:0] lin3_ff;
   logic          neg3_ff;

   if (ADW > hoasl_pkg::NORM_BITS) begin : g_norm
      localparam int EXTRA = ADW - hoasl_pkg::NORM_BITS;
      localparam int KW    = $clog2(EXTRA + 1);
      logic [KW-1:0] shift;

      // one past the highest set bit above the limit
      always_comb begin
         shift = '0;
         for (int j = 0; j < EXTRA; j++) begin
            if (ad_ff[hoasl_pkg::NORM_BITS + j]) shift = KW'(j + 1);
         end
      end

      assign ad_n_in = NW'(ad_ff >> shift);
      assign r_n_in  = cfg_range >> shift;
   end else begin : g_no_norm
      assign ad_n_in = ad_ff;
      assign r_n_in  = cfg_range;
   end

   always_ff @(posedge clock) begin
      if (take3) begin
         ad_n_ff <= ad_n_in;
         r_n_ff  <= r_n_in;
         neg3_ff <= neg2_ff;
         lin3_ff <= lin2_ff;
      end
   end

   // stage 4: cordic start vector, x = range * 2^13, y = +-offset * pi
   logic [YMW-1:0]              y_mag;
   logic signed [DATA_WIDTH-1:0] y_pos;
   logic signed [DATA_WIDTH-1:0] x4_in, x4_ff, y4_in, y4_ff;
   logic signed [W-1:0]          lin4_ff;

   always_comb begin
      y_mag = ad_n_ff * hoasl_pkg::PI_Q13;
      y_pos = $signed(DATA_WIDTH'(y_mag));
      y4_in = neg3_ff ? -y_pos : y_pos;
      x4_in = $signed(DATA_WIDTH'({r_n_ff, {hoasl_pkg::X_SHIFT{1'b0}}}));
   end

   always_ff @(posedge clock) begin
      if (take4) begin
         x4_ff   <= x4_in;
         y4_ff   <= y4_in;
         lin4_ff <= lin3_ff;
      end
   end

   assign out_valid = vld4_ff;
   assign out_x     = x4_ff;
   assign out_y     = y4_ff;
   assign out_lin   = lin4_ff;

endmodule

// ----- sv/hoasl_cell.sv -----
// hoasl_cell: one vectoring cordic rotation with its own pipeline register;
// uses hoasl_pkg for the angle table
`timescale 1ns / 1ps

module hoasl_cell #(
   parameter int DATA_WIDTH = 50,
   parameter int LIN_WIDTH  = 16,
   parameter int STAGE      = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_take,
   input  logic signed [DATA_WIDTH-1:0]              in_x,
   input  logic signed [DATA_WIDTH-1:0]              in_y,
   input  logic signed [hoasl_pkg::ANGLE_BITS-1:0]   in_z,
   input  logic signed [LIN_WIDTH-1:0]               in_lin,
   output logic                                      out_valid,
   input  logic                                      out_take,
   output logic signed [DATA_WIDTH-1:0]              out_x,
   output logic signed [DATA_WIDTH-1:0]              out_y,
   output logic signed [hoasl_pkg::ANGLE_BITS-1:0]   out_z,
   output logic signed [LIN_WIDTH-1:0]               out_lin
);

   localparam logic signed [hoasl_pkg::ANGLE_BITS-1:0] ANGLE_STEP =
      hoasl_pkg::atan_entry(STAGE);

   logic                                    vld_ff;
   logic signed [DATA_WIDTH-1:0]            x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [hoasl_pkg::ANGLE_BITS-1:0] z_ff, z_in;
   logic signed [LIN_WIDTH-1:0]             lin_ff;

   assign in_take = !vld_ff || out_take;

   // rotate towards the x axis, old x and y on the right
   always_comb begin
      xs = in_x >>> STAGE;
      ys = in_y >>> STAGE;
      if (!in_y[DATA_WIDTH-1]) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ANGLE_STEP;
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ANGLE_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_take) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         lin_ff <= in_lin;
      end
   end

   assign out_valid = vld_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_lin   = lin_ff;

endmodule

// ----- sv/hoasl_back.sv -----
// hoasl_back: angle scaling by the range, rounding, mid offset, clamp, mode
// choice and the output register; uses hoasl_pkg
`timescale 1ns / 1ps

module hoasl_back #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_take,
   input  logic signed [hoasl_pkg::ANGLE_BITS-1:0] in_z,
   input  logic signed [SAMPLE_WIDTH-1:0]          in_lin,
   input  logic signed [SAMPLE_WIDTH-1:0]          cfg_bottom,
   input  logic signed [SAMPLE_WIDTH-1:0]          cfg_top,
   input  logic signed [SAMPLE_WIDTH-1:0]          cfg_mid,
   input  logic        [SAMPLE_WIDTH-1:0]          cfg_range,
   input  hoasl_pkg::curve_mode_type               cfg_mode,
   input  logic                                    cfg_error,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0]          rsp_limited,
   output logic                                    rsp_config_error
);

   localparam int W  = SAMPLE_WIDTH;
   localparam int PW = W + 1 + hoasl_pkg::ANGLE_BITS;
   localparam int SW = W + 3;
   localparam logic signed [PW-1:0] HALF = PW'(2 ** (hoasl_pkg::ROUND_SHIFT - 1));

   logic vld_ff, rsp_valid_ff;
   logic take_rsp, take_prod;

   assign take_rsp  = !rsp_valid_ff || !rsp_stall;
   assign take_prod = !vld_ff || take_rsp;
   assign in_take   = take_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take_prod) vld_ff <= in_valid;
         if (take_rsp) rsp_valid_ff <= vld_ff;
      end
   end

   // range times angle
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [W-1:0]  lin_ff;

   assign prod_in = $signed({1'b0, cfg_range}) * in_z;

   always_ff @(posedge clock) begin
      if (take_prod) begin
         prod_ff <= prod_in;
         lin_ff  <= in_lin;
      end
   end

   // round, add mid, clamp and pick the mode
   logic signed [PW-1:0] rnd;
   logic signed [SW-1:0] soft_sum;
   logic signed [SW-1:0] bot_w, top_w;
   logic signed [W-1:0]  soft_clamp;
   logic signed [W-1:0]  limited_in, limited_ff;
   logic                 error_ff;

   always_comb begin
      rnd      = (prod_ff + HALF) >>> hoasl_pkg::ROUND_SHIFT;
      bot_w    = {{(SW-W){cfg_bottom[W-1]}}, cfg_bottom};
      top_w    = {{(SW-W){cfg_top[W-1]}}, cfg_top};
      soft_sum = rnd[SW-1:0] + {{(SW-W){cfg_mid[W-1]}}, cfg_mid};
      if (soft_sum < bot_w)
         soft_clamp = cfg_bottom;
      else if (soft_sum > top_w)
         soft_clamp = cfg_top;
      else
         soft_clamp = soft_sum[W-1:0];

      if (cfg_error)
         limited_in = '0;
      else if (cfg_mode == hoasl_pkg::MODE_LINEAR)
         limited_in = lin_ff;
      else if (cfg_top == cfg_bottom)
         limited_in = cfg_bottom;
      else
         limited_in = soft_clamp;
   end

   always_ff @(posedge clock) begin
      if (take_rsp) begin
         limited_ff <= limited_in;
         error_ff   <= cfg_error;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_limited      = limited_ff;
   assign rsp_config_error = error_ff;

endmodule

// ----- sv/hard_or_atan_soft_limiter.sv -----
// hard_or_atan_soft_limiter: top level, configuration registers and the
// cordic cell row; uses hoasl_pkg, hoasl_front, hoasl_cell and hoasl_back
`timescale 1ns / 1ps

// Stateless sample limiter for signed fixed-point words. Each word on req_
// is multiplied by the gain and then either clamped to [bottom_level,
// top_level] (linear mode) or shaped by an arctangent soft limit around the
// mid level (atan mode), computed by a row of vectoring cordic cells with
// atan2(pi*d, top-bottom), so no divider is involved. The block takes one
// word per clock and gives one result word per input word, in order; the
// pipeline is 4 front stages, min(CORDIC_STAGES, 32) cordic cells and 2 back
// stages deep. Every stage has its own valid bit, so bubbles close up and a
// word is accepted whenever any stage can move; req_stall rises only when
// every stage is full and the result word is held by rsp_stall. A zero gain
// or bottom above top gives config_error with a zero result. The user must
// write registers through csr_ only while no word is in flight; the block
// itself does not enforce this.

module hard_or_atan_soft_limiter #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int FRAC_BITS     = 12,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   // input words
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   // result words
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_limited,
   output logic                           rsp_config_error,
   // register writes
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [SAMPLE_WIDTH-1:0]        csr_wdata
);

   localparam int W   = SAMPLE_WIDTH;
   localparam int ADW = 2 * W;
   localparam int NW  = (ADW > hoasl_pkg::NORM_BITS) ? hoasl_pkg::NORM_BITS : ADW;
   localparam int YMW = NW + hoasl_pkg::PI_BITS;
   localparam int XMW = W + hoasl_pkg::X_SHIFT;
   // room for the cordic gain and a sign on top of the larger start operand
   localparam int CW  = ((YMW > XMW) ? YMW : XMW) + 3;
   localparam int NS  = (CORDIC_STAGES < hoasl_pkg::MAX_STAGES) ?
                        CORDIC_STAGES : hoasl_pkg::MAX_STAGES;
   localparam int AB  = hoasl_pkg::ANGLE_BITS;

   // configuration registers, reset to unity gain and levels [0, 1.0]
   logic signed [W-1:0]       gain_ff, bottom_ff, top_ff;
   hoasl_pkg::curve_mode_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= $signed({{(W-1){1'b0}}, 1'b1} << FRAC_BITS);
         bottom_ff <= '0;
         top_ff    <= $signed({{(W-1){1'b0}}, 1'b1} << FRAC_BITS);
         mode_ff   <= hoasl_pkg::MODE_LINEAR;
      end else if (csr_wr_en) begin
         unique case (hoasl_pkg::csr_index_type'(csr_index))
            hoasl_pkg::CSR_GAIN:   gain_ff   <= $signed(csr_wdata);
            hoasl_pkg::CSR_BOTTOM: bottom_ff <= $signed(csr_wdata);
            hoasl_pkg::CSR_TOP:    top_ff    <= $signed(csr_wdata);
            hoasl_pkg::CSR_MODE:   mode_ff   <= hoasl_pkg::curve_mode_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   // derived levels, stable while words are in flight if no register is written
   logic [W:0]          mid_sum;
   logic signed [W-1:0] mid;
   logic [W-1:0]        range;
   logic                cfg_error;

   assign mid_sum   = {top_ff[W-1], top_ff} + {bottom_ff[W-1], bottom_ff};
   assign mid       = $signed(mid_sum[W:1]);
   assign range     = top_ff - bottom_ff;
   assign cfg_error = (gain_ff == '0) || (bottom_ff > top_ff);

   // links along the cell row, entry 0 from the front end
   logic                 vld_chain  [NS+1];
   logic                 take_chain [NS+1];
   logic signed [CW-1:0] x_chain    [NS+1];
   logic signed [CW-1:0] y_chain    [NS+1];
   logic signed [AB-1:0] z_chain    [NS+1];
   logic signed [W-1:0]  lin_chain  [NS+1];
   logic                 front_take;

   assign req_stall  = !front_take;
   assign z_chain[0] = '0;

   hoasl_front #(
      .SAMPLE_WIDTH (W),
      .FRAC_BITS    (FRAC_BITS),
      .DATA_WIDTH   (CW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_take    (front_take),
      .in_sample  (req_sample),
      .cfg_gain   (gain_ff),
      .cfg_bottom (bottom_ff),
      .cfg_top    (top_ff),
      .cfg_mid    (mid),
      .cfg_range  (range),
      .out_valid  (vld_chain[0]),
      .out_take   (take_chain[0]),
      .out_x      (x_chain[0]),
      .out_y      (y_chain[0]),
      .out_lin    (lin_chain[0])
   );

   // one rotation per cell, the linear result rides alongside
   for (genvar i = 0; i < NS; i++) begin : g_cell
      hoasl_cell #(
         .DATA_WIDTH (CW),
         .LIN_WIDTH  (W),
         .STAGE      (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld_chain[i]),
         .in_take   (take_chain[i]),
         .in_x      (x_chain[i]),
         .in_y      (y_chain[i]),
         .in_z      (z_chain[i]),
         .in_lin    (lin_chain[i]),
         .out_valid (vld_chain[i+1]),
         .out_take  (take_chain[i+1]),
         .out_x     (x_chain[i+1]),
         .out_y     (y_chain[i+1]),
         .out_z     (z_chain[i+1]),
         .out_lin   (lin_chain[i+1])
      );
   end

   hoasl_back #(
      .SAMPLE_WIDTH (W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (vld_chain[NS]),
      .in_take          (take_chain[NS]),
      .in_z             (z_chain[NS]),
      .in_lin           (lin_chain[NS]),
      .cfg_bottom       (bottom_ff),
      .cfg_top          (top_ff),
      .cfg_mid          (mid),
      .cfg_range        (range),
      .cfg_mode         (mode_ff),
      .cfg_error        (cfg_error),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_limited      (rsp_limited),
      .rsp_config_error (rsp_config_error)
   );

   // the cell row and the slicing of x and y are unused in the top for x/y
   // beyond the last cell, which only feeds the angle forward

   // a flagged word always carries a zero sample
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_error |-> rsp_limited == '0)
      else $error("config error word with non-zero sample");

   // input back-pressure only when the result word is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while the pipeline could move");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

endmodule
